>>> hw/rtl/boundary_endpoint_pair_stitcher_core_assert.svh
// Assertion macros for the endpoint pair stitcher checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BOUNDARY_ENDPOINT_PAIR_STITCHER_CORE_ASSERT_SVH
`define BOUNDARY_ENDPOINT_PAIR_STITCHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BEPSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BEPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bepsc_pkg.sv
// Shared types and codes for the endpoint pair stitcher.
// No dependencies.
`timescale 1ns / 1ps

package bepsc_pkg;

    localparam int MAX_EP_DEFAULT = 16;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_FETCH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_OVF     = 2'd2;
    localparam logic [1:0] ST_NO_PAIR = 2'd3;

    localparam logic [6:0] PAIR_SAT = 7'd127;

    // key in the top bits, so a plain compare gives key, part, node order
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] part;
        logic [31:0] node;
    } t_entry;

endpackage

>>> hw/rtl/bepsc_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module bepsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

>>> hw/rtl/boundary_endpoint_pair_stitcher_core.sv
// Load: walk down from the top, shifting each larger entry up one slot; overflow status when the store is full.
// Run: overflow status after an overflow, else a duplicate scan over the adjacent pairs,
//   then the pair walk: one (a,b) probe at a time, moving to the next row when b runs out.
// Fetch: no-pair status with no pair pending, else read that pair, then walk to the next pair as above.
// One request at a time; the single two-read RAM port pair paces every step.
// Reset clears control state only; store contents are undefined, no clearing pass.
`timescale 1ns / 1ps

module boundary_endpoint_pair_stitcher_core
    import bepsc_pkg::*;
#(
    parameter int MAX_ENDPOINTS = MAX_EP_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_boundary_key,
    input  logic [31:0] i_part_id,
    input  logic [31:0] i_node_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_pair_count,
    output logic [31:0] o_first_node,
    output logic [31:0] o_second_node,
    output logic        o_pair_valid,
    output logic        o_last_pair
);

    localparam int AW = $clog2(MAX_ENDPOINTS);
    localparam int XW = $clog2(MAX_ENDPOINTS + 2);
    localparam logic [XW-1:0] CAP = XW'(MAX_ENDPOINTS);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LD_RD   = 9'b000000010,
        S_LD_CMP  = 9'b000000100,
        S_DUP_RD  = 9'b000001000,
        S_DUP_CMP = 9'b000010000,
        S_WK_RD   = 9'b000100000,
        S_WK_CMP  = 9'b001000000,
        S_FT_RD   = 9'b010000000,
        S_FT_CAP  = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [XW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_fetching, n_fetching;
    logic [XW-1:0] r_cf, n_cf, r_cs, n_cs;
    logic [XW-1:0] r_j, n_j;
    logic [XW-1:0] r_a, n_a, r_b, n_b;
    logic          r_count_mode, n_count_mode;
    logic [6:0]    r_pairs, n_pairs;
    logic          r_found, n_found;
    logic [XW-1:0] r_fa, n_fa, r_fb, n_fb;
    t_entry        r_new, n_new;

    logic          r_ov, n_ov;
    logic [1:0]    r_st, n_st;
    logic [6:0]    r_pc, n_pc;
    logic [31:0]   r_n1, n_n1, r_n2, n_n2;
    logic          r_pv, n_pv, r_lp, n_lp;

    logic          ram_we;
    logic [AW-1:0] ram_wa, ram_ra0, ram_ra1;
    t_entry        ram_wd, rd0, rd1;
    logic          in_acc;

    bepsc_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_ENDPOINTS)) u_store (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_wa),
        .i_wdata  (ram_wd),
        .i_raddr0 (ram_ra0),
        .i_raddr1 (ram_ra1),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    assign o_in_ready = (r_state == S_IDLE) && !r_ov;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_fetching   = r_fetching;
        n_cf         = r_cf;
        n_cs         = r_cs;
        n_j          = r_j;
        n_a          = r_a;
        n_b          = r_b;
        n_count_mode = r_count_mode;
        n_pairs      = r_pairs;
        n_found      = r_found;
        n_fa         = r_fa;
        n_fb         = r_fb;
        n_new        = r_new;
        n_ov         = r_ov && !i_out_ready;
        n_st         = r_st;
        n_pc         = r_pc;
        n_n1         = r_n1;
        n_n2         = r_n2;
        n_pv         = r_pv;
        n_lp         = r_lp;
        ram_we       = 1'b0;
        ram_wa       = r_j[AW-1:0];
        ram_wd       = r_new;
        ram_ra0      = r_a[AW-1:0];
        ram_ra1      = r_b[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ov = 1'b1;
                    n_st = ST_OK;
                    n_pc = '0;
                    n_n1 = '0;
                    n_n2 = '0;
                    n_pv = 1'b0;
                    n_lp = 1'b0;
                    n_ov = 1'b0;
                    unique case (i_func)
                        FUNC_LOAD: begin
                            if (r_fetching) begin
                                n_count    = '0;
                                n_ovf      = 1'b0;
                                n_fetching = 1'b0;
                                n_cf       = '0;
                                n_cs       = '0;
                                n_new      = '{i_boundary_key, i_part_id, i_node_id};
                                n_j        = '0;
                                n_state    = S_LD_RD;
                            end else if (r_count >= CAP) begin
                                n_ovf = 1'b1;
                                n_st  = ST_OVF;
                                n_ov  = 1'b1;
                            end else begin
                                n_new   = '{i_boundary_key, i_part_id, i_node_id};
                                n_j     = r_count;
                                n_state = S_LD_RD;
                            end
                        end
                        FUNC_RUN: begin
                            if (r_ovf) begin
                                n_st       = ST_OVF;
                                n_ov       = 1'b1;
                                n_count    = '0;
                                n_ovf      = 1'b0;
                                n_fetching = 1'b0;
                                n_cf       = '0;
                                n_cs       = '0;
                            end else begin
                                n_j     = XW'(1);
                                n_state = S_DUP_RD;
                            end
                        end
                        FUNC_FETCH: begin
                            if (!r_fetching) begin
                                n_st = ST_NO_PAIR;
                                n_ov = 1'b1;
                            end else begin
                                n_state = S_FT_RD;
                            end
                        end
                        default: begin
                            n_ov = 1'b1;
                        end
                    endcase
                end
            end

            // walk down from the top, shifting larger entries up by one
            S_LD_RD: begin
                ram_ra0 = AW'(r_j - 1'b1);
                if (r_j == '0) begin
                    ram_we  = 1'b1;
                    n_count = XW'(r_count + 1'b1);
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LD_CMP;
                end
            end

            S_LD_CMP: begin
                ram_we = 1'b1;
                if (rd0 > r_new) begin
                    ram_wd  = rd0;
                    n_j     = XW'(r_j - 1'b1);
                    n_state = S_LD_RD;
                end else begin
                    n_count = XW'(r_count + 1'b1);
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_DUP_RD: begin
                ram_ra0 = AW'(r_j - 1'b1);
                ram_ra1 = r_j[AW-1:0];
                if (r_j >= r_count) begin
                    n_a          = '0;
                    n_b          = XW'(1);
                    n_pairs      = '0;
                    n_found      = 1'b0;
                    n_count_mode = 1'b1;
                    n_state      = S_WK_RD;
                end else begin
                    n_state = S_DUP_CMP;
                end
            end

            S_DUP_CMP: begin
                if (rd0 == rd1) begin
                    n_st       = ST_DUP;
                    n_ov       = 1'b1;
                    n_count    = '0;
                    n_ovf      = 1'b0;
                    n_fetching = 1'b0;
                    n_cf       = '0;
                    n_cs       = '0;
                    n_state    = S_IDLE;
                end else begin
                    n_j     = XW'(r_j + 1'b1);
                    n_state = S_DUP_RD;
                end
            end

            S_WK_RD: begin
                if (r_a >= r_count) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                    if (r_count_mode && r_found) begin
                        n_pc       = r_pairs;
                        n_cf       = r_fa;
                        n_cs       = r_fb;
                        n_fetching = 1'b1;
                    end else begin
                        n_pc       = r_pairs;
                        n_lp       = !r_count_mode;
                        n_count    = '0;
                        n_ovf      = 1'b0;
                        n_fetching = 1'b0;
                        n_cf       = '0;
                        n_cs       = '0;
                    end
                end else if (r_b >= r_count) begin
                    n_a = XW'(r_a + 1'b1);
                    n_b = XW'(r_a + 2'd2);
                end else begin
                    n_state = S_WK_CMP;
                end
            end

            S_WK_CMP: begin
                n_state = S_WK_RD;
                if (rd0.key != rd1.key) begin
                    n_a = XW'(r_a + 1'b1);
                    n_b = XW'(r_a + 2'd2);
                end else if (rd0.part != rd1.part) begin
                    if (r_count_mode) begin
                        if (r_pairs != PAIR_SAT) begin
                            n_pairs = r_pairs + 7'd1;
                        end
                        if (!r_found) begin
                            n_found = 1'b1;
                            n_fa    = r_a;
                            n_fb    = r_b;
                        end
                        n_b = XW'(r_b + 1'b1);
                    end else begin
                        n_cf    = r_a;
                        n_cs    = r_b;
                        n_ov    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_b = XW'(r_b + 1'b1);
                end
            end

            S_FT_RD: begin
                ram_ra0 = r_cf[AW-1:0];
                ram_ra1 = r_cs[AW-1:0];
                n_state = S_FT_CAP;
            end

            S_FT_CAP: begin
                n_n1         = rd0.node;
                n_n2         = rd1.node;
                n_pv         = 1'b1;
                n_a          = r_cf;
                n_b          = XW'(r_cs + 1'b1);
                n_pairs      = '0;
                n_count_mode = 1'b0;
                n_state      = S_WK_RD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_fetching <= 1'b0;
            r_cf       <= '0;
            r_cs       <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_fetching <= n_fetching;
            r_cf       <= n_cf;
            r_cs       <= n_cs;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_a          <= n_a;
        r_b          <= n_b;
        r_count_mode <= n_count_mode;
        r_pairs      <= n_pairs;
        r_found      <= n_found;
        r_fa         <= n_fa;
        r_fb         <= n_fb;
        r_new        <= n_new;
        r_st         <= n_st;
        r_pc         <= n_pc;
        r_n1         <= n_n1;
        r_n2         <= n_n2;
        r_pv         <= n_pv;
        r_lp         <= n_lp;
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_st;
    assign o_pair_count  = r_pc;
    assign o_first_node  = r_n1;
    assign o_second_node = r_n2;
    assign o_pair_valid  = r_pv;
    assign o_last_pair   = r_lp;

endmodule

>>> hw/rtl/bepsc_checker.sv
// Port-level checker for the endpoint pair stitcher, bound to the top level.
// Depends on boundary_endpoint_pair_stitcher_core_assert.svh.
`timescale 1ns / 1ps
`include "boundary_endpoint_pair_stitcher_core_assert.svh"

module bepsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [6:0]  o_pair_count,
    input logic [31:0] o_first_node,
    input logic [31:0] o_second_node,
    input logic        o_pair_valid,
    input logic        o_last_pair
);

    `BEPSC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_first_node), "result dropped while stalled")
    `BEPSC_ASSERT_NOW(a_pair_ok, o_out_valid && o_pair_valid, o_status == 2'd0 && o_pair_count == 7'd0, "pair with bad status or count")
    `BEPSC_ASSERT_NOW(a_last_has_pair, o_out_valid && o_last_pair, o_pair_valid, "last flag without a pair")
    `BEPSC_ASSERT_NOW(a_no_pair_zero, o_out_valid && !o_pair_valid, o_first_node == 32'd0 && o_second_node == 32'd0, "nodes set without a pair")

endmodule

bind boundary_endpoint_pair_stitcher_core bepsc_checker u_bepsc_checker (.*);
